// ===== rtl/smds_pkg.sv =====
// Shared constants, command codes and controller/datapath link types for the double stack.
package smds_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  localparam logic SIDE_LOW  = 1'b0;
  localparam logic SIDE_HIGH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/smds_req_if.sv =====
// Request channel: one stack operation per beat.
interface smds_req_if;
  import smds_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic              side;
  logic [DATA_W-1:0] push_data;

  modport source (output valid, output cmd, output side, output push_data, input ready);
  modport sink   (input valid, input cmd, input side, input push_data, output ready);
endinterface

// ===== rtl/smds_rsp_if.sv =====
// Response channel: one result per beat.
interface smds_rsp_if;
  import smds_pkg::*;

  logic              valid;
  logic              ready;
  logic              ok;
  logic [DATA_W-1:0] read_data;
  logic [CNT_W-1:0]  used_words;

  modport source (output valid, output ok, output read_data, output used_words, input ready);
  modport sink   (input valid, input ok, input read_data, input used_words, output ready);
endinterface

// ===== rtl/smds_ctrl.sv =====
// Sequencer: accept an item, execute it, then load the result register.
module smds_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  smds_pkg::dp_status_t  status,
  output smds_pkg::dp_cmd_t     cmd
);
  import smds_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.load_item = 1'b0;
    cmd.exec      = 1'b0;
    cmd.load_out  = 1'b0;
    req_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.load_item = req_valid;
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the result register frees up
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ST_EXEC)
    else $error("accepted beat not followed by execute");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !status.out_busy)
    else $error("result loaded over a pending beat");
endmodule

// ===== rtl/smds_dp.sv =====
// Datapath: item registers, stack counters, shared word memory and result register.
module smds_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  smds_pkg::dp_cmd_t             cmd,
  output smds_pkg::dp_status_t          status,
  input  logic [1:0]                    req_cmd,
  input  logic                          req_side,
  input  logic [smds_pkg::DATA_W-1:0]   req_push_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          rsp_ok,
  output logic [smds_pkg::DATA_W-1:0]   rsp_read_data,
  output logic [smds_pkg::CNT_W-1:0]    rsp_used_words
);
  import smds_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  cmd_t              op;
  logic              side_q;
  logic [DATA_W-1:0] data_q;
  logic [CNT_W-1:0]  low_count, high_count;
  logic [CNT_W-1:0]  low_count_next, high_count_next;
  logic              ok_q, rd_en_q;
  logic [DATA_W-1:0] rd_q;

  logic [CNT_W-1:0]  used;
  logic              full;
  logic [CNT_W-1:0]  sel_count;
  logic              exec_ok;
  logic              wr_en;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  addr_wide;

  assign used      = low_count + high_count;
  assign full      = (used == CNT_W'(DEPTH));
  assign sel_count = (side_q == SIDE_LOW) ? low_count : high_count;

  always_comb begin
    exec_ok         = 1'b0;
    wr_en           = 1'b0;
    low_count_next  = low_count;
    high_count_next = high_count;
    unique case (op) inside
      CMD_CLEAR: begin
        exec_ok         = 1'b1;
        low_count_next  = '0;
        high_count_next = '0;
      end
      CMD_PUSH: begin
        if (!full) begin
          exec_ok = 1'b1;
          wr_en   = 1'b1;
          if (side_q == SIDE_LOW) low_count_next = low_count + CNT_W'(1);
          else                    high_count_next = high_count + CNT_W'(1);
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (sel_count != '0) begin
          exec_ok = 1'b1;
          if (op == CMD_POP) begin
            if (side_q == SIDE_LOW) low_count_next = low_count - CNT_W'(1);
            else                    high_count_next = high_count - CNT_W'(1);
          end
        end
      end
      default: exec_ok = 1'b0;
    endcase
  end

  // Push targets the slot past the top; pop and peek read the top itself.
  always_comb begin
    if (op == CMD_PUSH) begin
      addr_wide = (side_q == SIDE_LOW) ? low_count
                                       : CNT_W'(DEPTH - 1) - high_count;
    end else begin
      addr_wide = (side_q == SIDE_LOW) ? low_count - CNT_W'(1)
                                       : CNT_W'(DEPTH) - high_count;
    end
  end
  assign addr = addr_wide[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) mem[addr] <= data_q;
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op     <= cmd_t'(req_cmd);
      side_q <= req_side;
      data_q <= req_push_data;
    end
    if (cmd.exec) begin
      ok_q    <= exec_ok;
      rd_en_q <= exec_ok && (op == CMD_POP || op == CMD_PEEK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_count  <= '0;
      high_count <= '0;
    end else if (cmd.exec) begin
      low_count  <= low_count_next;
      high_count <= high_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp_ok         <= ok_q;
      rsp_read_data  <= rd_en_q ? rd_q : '0;
      rsp_used_words <= used;
    end
  end

  assign status.out_busy = rsp_valid && !rsp_ready;

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(DEPTH))
    else $error("stacks hold more words than the memory");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && op == CMD_CLEAR |=> low_count == '0 && high_count == '0)
    else $error("clear left words behind");

  a_fail_keeps_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && !exec_ok |=> $stable(low_count) && $stable(high_count))
    else $error("failed operation changed a count");
endmodule

// ===== rtl/shared_memory_double_stack.sv =====
// Two LIFO stacks in one 256-word memory, the low stack growing up from word 0 and the high
// stack growing down from the top word. Each request beat is a push, pop, peek or clear and
// gives exactly one response beat with a success flag, the word read and the total word
// count. One item is in work at a time: an item passes through acceptance, one access on the memory
// port and the result load (states IDLE, EXEC, LOAD), and no new beat is taken until its result
// is loaded, which waits while the response register still holds an unread result; that register
// lets the next beat be accepted while a result still waits. No clearing pass follows reset.
module shared_memory_double_stack (
  input logic        clk,
  input logic        rst,
  smds_req_if.sink   req,
  smds_rsp_if.source rsp
);
  import smds_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       ready;

  smds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  assign req.ready = ready;

  smds_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (dp_cmd),
    .status         (dp_status),
    .req_cmd        (req.cmd),
    .req_side       (req.side),
    .req_push_data  (req.push_data),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ok         (rsp.ok),
    .rsp_read_data  (rsp.read_data),
    .rsp_used_words (rsp.used_words)
  );
endmodule

// ===== test/tb.sv =====
// Testbench for the two-stacks-in-one-memory block: random push/pop/peek/clear with a scoreboard.
`timescale 1ns / 100ps

import smds_pkg::*;

typedef struct {
  logic              ok;
  logic [DATA_W-1:0] read_data;
  logic [CNT_W-1:0]  used_words;
} stack_result_t;

class stack_pair_ledger;
  logic [DATA_W-1:0] words [DEPTH];
  int                low_count;
  int                high_count;
  stack_result_t     pending_results[$];
  int                mismatches;
  int                strays;

  function new();
    low_count   = 0;
    high_count  = 0;
    mismatches  = 0;
    strays      = 0;
  endfunction

  function int used();
    return low_count + high_count;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function int errors();
    return mismatches + strays;
  endfunction

  // Apply one accepted operation to the shadow stacks and queue its result.
  function void apply_op(cmd_t op, logic side, logic [DATA_W-1:0] data);
    stack_result_t r;
    int            depth_now;
    r.ok        = 1'b0;
    r.read_data = '0;
    case (op)
      CMD_CLEAR: begin
        low_count  = 0;
        high_count = 0;
        r.ok       = 1'b1;
      end
      CMD_PUSH: begin
        if (used() < DEPTH) begin
          if (side == SIDE_LOW) begin
            words[low_count] = data;
            low_count++;
          end else begin
            high_count++;
            words[DEPTH - high_count] = data;
          end
          r.ok = 1'b1;
        end
      end
      default: begin
        depth_now = (side == SIDE_LOW) ? low_count : high_count;
        if (depth_now != 0) begin
          r.read_data = (side == SIDE_LOW) ? words[low_count - 1] : words[DEPTH - high_count];
          r.ok        = 1'b1;
          if (op == CMD_POP) begin
            if (side == SIDE_LOW) low_count--;
            else high_count--;
          end
        end
      end
    endcase
    r.used_words = CNT_W'(used());
    pending_results.push_back(r);
  endfunction

  function void check_result(logic ok, logic [DATA_W-1:0] read_data,
                             logic [CNT_W-1:0] used_words);
    stack_result_t e;
    if (pending_results.size() == 0) begin
      strays++;
      if (errors() <= 10)
        $display("%0t: response beat with no request waiting: ok=%0b data=%h used=%0d",
                 $realtime, ok, read_data, used_words);
      return;
    end
    e = pending_results.pop_front();
    if (ok !== e.ok || read_data !== e.read_data || used_words !== e.used_words) begin
      mismatches++;
      if (errors() <= 10)
        $display("%0t: mismatch: expected ok=%0b data=%h used=%0d, got ok=%0b data=%h used=%0d",
                 $realtime, e.ok, e.read_data, e.used_words, ok, read_data, used_words);
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst;

  smds_req_if req ();
  smds_rsp_if rsp ();

  shared_memory_double_stack dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  stack_pair_ledger ledger = new();
  int               issued;
  bit               req_calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic pick_side(int high_pct);
    return ($urandom_range(0, 99) < high_pct) ? SIDE_HIGH : SIDE_LOW;
  endfunction

  function automatic cmd_t mixed_cmd();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return CMD_PUSH;
    if (roll < 70) return CMD_POP;
    if (roll < 95) return CMD_PEEK;
    return CMD_CLEAR;
  endfunction

  task automatic send_op(input cmd_t op, input logic side, input logic [DATA_W-1:0] data);
    int gap;
    gap = pick_gap(req_calm);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.cmd       <= op;
    req.side      <= side;
    req.push_data <= data;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    ledger.apply_op(op, side, data);
    issued++;
  endtask

  // Push until the memory is full, then beat on it a few more times.
  task automatic fill_segment();
    int bias;
    int extra;
    bias = $urandom_range(0, 100);
    while (ledger.used() < DEPTH) begin
      if ($urandom_range(0, 99) < 8) send_op(CMD_PEEK, pick_side(bias), $urandom);
      else send_op(CMD_PUSH, pick_side(bias), $urandom);
    end
    extra = $urandom_range(1, 4);
    repeat (extra) send_op(CMD_PUSH, pick_side(50), $urandom);
  endtask

  // Pop until both stacks are empty, then read the empty stacks.
  task automatic drain_segment();
    logic side;
    int   extra;
    while (ledger.used() != 0) begin
      if (ledger.low_count == 0) side = SIDE_HIGH;
      else if (ledger.high_count == 0) side = SIDE_LOW;
      else side = pick_side(50);
      if ($urandom_range(0, 99) < 85) send_op(CMD_POP, side, $urandom);
      else send_op(CMD_PEEK, side, $urandom);
    end
    extra = $urandom_range(1, 4);
    repeat (extra) begin
      if ($urandom_range(0, 1) == 0) send_op(CMD_POP, pick_side(50), $urandom);
      else send_op(CMD_PEEK, pick_side(50), $urandom);
    end
  endtask

  task automatic mixed_segment();
    int len;
    len = $urandom_range(10, 60);
    repeat (len) send_op(mixed_cmd(), pick_side(50), $urandom);
  endtask

  // Response side: check every beat, stall at random.
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready)
        ledger.check_result(rsp.ok, rsp.read_data, rsp.used_words);
      if (calm_left > 0) begin
        rsp.ready <= 1'b1;
        calm_left--;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
        else stall_left = pick_gap(1'b0);
      end
    end
  end

  initial begin
    int seg;
    bit first_fill;
    issued        = 0;
    req_calm      = 1'b0;
    first_fill    = 1'b1;
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.cmd       = CMD_PUSH;
    req.side      = SIDE_LOW;
    req.push_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty stacks, data extremes, both sides, clear with either side.
    send_op(CMD_POP,   SIDE_LOW,  32'h1234_5678);
    send_op(CMD_PEEK,  SIDE_HIGH, 32'h0);
    send_op(CMD_POP,   SIDE_HIGH, 32'hFFFF_FFFF);
    send_op(CMD_PEEK,  SIDE_LOW,  32'h0);
    send_op(CMD_PUSH,  SIDE_LOW,  32'h0000_0000);
    send_op(CMD_PUSH,  SIDE_LOW,  32'hFFFF_FFFF);
    send_op(CMD_PUSH,  SIDE_HIGH, 32'h8000_0000);
    send_op(CMD_PUSH,  SIDE_HIGH, 32'h0000_0001);
    send_op(CMD_PEEK,  SIDE_LOW,  32'h0);
    send_op(CMD_PEEK,  SIDE_HIGH, 32'h0);
    send_op(CMD_POP,   SIDE_LOW,  32'h0);
    send_op(CMD_POP,   SIDE_LOW,  32'h0);
    send_op(CMD_POP,   SIDE_LOW,  32'h0);
    send_op(CMD_POP,   SIDE_HIGH, 32'h0);
    send_op(CMD_PEEK,  SIDE_HIGH, 32'h0);
    send_op(CMD_CLEAR, SIDE_HIGH, 32'hDEAD_BEEF);
    send_op(CMD_POP,   SIDE_HIGH, 32'h0);
    send_op(CMD_PUSH,  SIDE_HIGH, 32'hA5A5_A5A5);
    send_op(CMD_PUSH,  SIDE_LOW,  32'h5A5A_5A5A);
    send_op(CMD_CLEAR, SIDE_LOW,  32'h0);
    send_op(CMD_PEEK,  SIDE_HIGH, 32'h0);
    send_op(CMD_PEEK,  SIDE_LOW,  32'h0);

    // Random: fill to full, drain to empty, mixed runs and clears.
    while (issued < 1800) begin
      req_calm = ($urandom_range(0, 4) == 0);
      seg      = first_fill ? 0 : $urandom_range(0, 9);
      first_fill = 1'b0;
      case (seg) inside
        0, 1: fill_segment();
        2, 3: drain_segment();
        9: send_op(CMD_CLEAR, pick_side(50), $urandom);
        default: mixed_segment();
      endcase
    end
    req.valid <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (ledger.errors() == 0 && ledger.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/smds_pkg.sv
rtl/smds_req_if.sv
rtl/smds_rsp_if.sv
rtl/smds_ctrl.sv
rtl/smds_dp.sv
rtl/shared_memory_double_stack.sv
test/tb.sv
